>>> rtl/ilo_pkg.sv
// Shared types and constants for the Ising lattice observables unit.
// No dependencies; ilo_if.sv and the top-level unit refer to this package.
package ilo_pkg;

   // Default build parameters
   localparam int MAX_SIDE_DEFAULT        = 64;
   localparam int TEMP_INDEX_BITS_DEFAULT = 10;

   // Configuration register widths and reset values
   localparam int LATTICE_SIZE_W     = 7;
   localparam int TARGET_INDEX_W     = 10;
   localparam int LATTICE_SIZE_RESET = 16;
   localparam int MIN_SIDE           = 2;

   // Result field widths
   localparam int MAG_SUM_W    = 14;
   localparam int MAG_ABS_W    = 13;
   localparam int ENERGY_W     = 15;
   localparam int BOND_DELTA_W = 4;

   // APB-style configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register map, indexed by paddr[2]
   typedef enum logic [0:0] {
      REG_LATTICE_SIZE = 1'b0,
      REG_TARGET_INDEX = 1'b1
   } ilo_reg_type;

endpackage

>>> rtl/ilo_if.sv
// Valid/ready channel interfaces for spin items and observable results.
// Depends on ilo_pkg for default widths of the payload fields.
interface ilo_req_if #(
   parameter int TEMP_INDEX_BITS = ilo_pkg::TEMP_INDEX_BITS_DEFAULT
);
   logic                       valid;
   logic                       ready;
   logic                       spin_up;
   logic [TEMP_INDEX_BITS-1:0] snapshot_temp_index;

   modport source (output valid, output spin_up, output snapshot_temp_index, input ready);
   modport sink   (input valid, input spin_up, input snapshot_temp_index, output ready);
endinterface

interface ilo_rsp_if #(
   parameter int TEMP_INDEX_BITS = ilo_pkg::TEMP_INDEX_BITS_DEFAULT
);
   logic                                      valid;
   logic                                      ready;
   logic signed [ilo_pkg::MAG_SUM_W-1:0]      magnetization_sum;
   logic        [ilo_pkg::MAG_ABS_W-1:0]      magnetization_abs;
   logic signed [ilo_pkg::ENERGY_W-1:0]       total_energy;
   logic        [TEMP_INDEX_BITS-1:0]         result_temp_index;

   modport source (output valid, output magnetization_sum, output magnetization_abs,
                   output total_energy, output result_temp_index, input ready);
   modport sink   (input valid, input magnetization_sum, input magnetization_abs,
                   input total_energy, input result_temp_index, output ready);
endinterface

>>> rtl/ilo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ilo_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ising_lattice_observables_unit.sv
// Ising lattice observables unit: spin sum and periodic nearest-neighbor energy.
// Depends on ilo_pkg, ilo_req_if / ilo_rsp_if and ilo_ram.
//
// Spins of an N x N snapshot enter in row-major order, one per transfer, and
// the unit takes one spin every clock cycle. A spin is registered at transfer
// together with its row/column position, while the neighbor spins of the row
// above and of the first row are read from two 1-bit x MAX_SIDE RAMs at the
// same edge; its magnetization and bond terms are added into the running sums
// as it leaves the input register. The last spin of a snapshot whose
// temperature index matches the target loads the result register as it
// leaves the input register; other snapshots give no result. A waiting
// result stalls only a further result-producing spin: that spin is held in
// the input register and the input stalls until the result is taken, while
// all other spins keep flowing one per cycle. Writing lattice_size restarts
// the snapshot; write configuration only while the unit is idle.
module ising_lattice_observables_unit #(
   parameter int MAX_SIDE        = ilo_pkg::MAX_SIDE_DEFAULT,
   parameter int TEMP_INDEX_BITS = ilo_pkg::TEMP_INDEX_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   ilo_req_if.sink                         req_port,
   ilo_rsp_if.source                       rsp_port,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ilo_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ilo_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ilo_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int COL_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CMP_W  = (SIDE_W > ilo_pkg::LATTICE_SIZE_W) ? SIDE_W
                                                              : ilo_pkg::LATTICE_SIZE_W;
   localparam logic [TEMP_INDEX_BITS-1:0] IDX_MASK =
      TEMP_INDEX_BITS'({ilo_pkg::TARGET_INDEX_W{1'b1}});

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [ilo_pkg::LATTICE_SIZE_W-1:0] size_ff;
   logic [TEMP_INDEX_BITS-1:0]         target_ff;
   logic                               csr_wr;
   logic                               restart;
   ilo_pkg::ilo_reg_type               csr_reg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = ilo_pkg::ilo_reg_type'(csr_paddr[2]);
   assign restart    = csr_wr && (csr_reg == ilo_pkg::REG_LATTICE_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= ilo_pkg::LATTICE_SIZE_W'(ilo_pkg::LATTICE_SIZE_RESET);
         target_ff <= '0;
      end else if (csr_wr) begin
         case (csr_reg)
            ilo_pkg::REG_LATTICE_SIZE: size_ff <= csr_pwdata[ilo_pkg::LATTICE_SIZE_W-1:0];
            ilo_pkg::REG_TARGET_INDEX:
               target_ff <= TEMP_INDEX_BITS'(csr_pwdata[ilo_pkg::TARGET_INDEX_W-1:0]);
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_reg)
         ilo_pkg::REG_LATTICE_SIZE: csr_prdata = ilo_pkg::CSR_DATA_W'(size_ff);
         ilo_pkg::REG_TARGET_INDEX: csr_prdata = ilo_pkg::CSR_DATA_W'(target_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // clamp side length to [2, MAX_SIDE]
   logic [CMP_W-1:0] size_ext;
   logic [CMP_W-1:0] side;

   always_comb begin
      size_ext = CMP_W'(size_ff);
      if (size_ext < CMP_W'(ilo_pkg::MIN_SIDE)) begin
         side = CMP_W'(ilo_pkg::MIN_SIDE);
      end else if (size_ext > CMP_W'(MAX_SIDE)) begin
         side = CMP_W'(MAX_SIDE);
      end else begin
         side = size_ext;
      end
   end

   // ------------------------------------------------------------------
   // Position counters, advanced at each input transfer
   // ------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] row_ff, row_in;
   logic             in_last_col;
   logic             in_last_row;
   logic             req_xfer;

   assign in_last_col = (CMP_W'(col_ff) + CMP_W'(1)) >= side;
   assign in_last_row = (CMP_W'(row_ff) + CMP_W'(1)) >= side;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_xfer) begin
         if (!in_last_col) begin
            col_in = col_ff + COL_W'(1);
         end else begin
            col_in = '0;
            row_in = in_last_row ? '0 : row_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Input stage register
   // ------------------------------------------------------------------
   logic                       s1_valid_ff;
   logic                       s1_spin_ff;
   logic [TEMP_INDEX_BITS-1:0] s1_tidx_ff;
   logic [COL_W-1:0]           s1_col_ff;
   logic                       s1_first_row_ff;
   logic                       s1_first_col_ff;
   logic                       s1_last_row_ff;
   logic                       s1_last_col_ff;
   logic                       s1_fire;
   logic                       s1_emit;

   assign req_port.ready = !s1_valid_ff || s1_fire;
   assign req_xfer       = req_port.valid && req_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         s1_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_spin_ff      <= req_port.spin_up;
         s1_tidx_ff      <= req_port.snapshot_temp_index & IDX_MASK;
         s1_col_ff       <= col_ff;
         s1_first_row_ff <= (row_ff == '0);
         s1_first_col_ff <= (col_ff == '0);
         s1_last_row_ff  <= in_last_row;
         s1_last_col_ff  <= in_last_col;
      end
   end

   // ------------------------------------------------------------------
   // Row memories: spins of the previous row and of the first row,
   // read at the transfer edge so data lines up with the stage register
   // ------------------------------------------------------------------
   logic prev_row_spin;
   logic first_row_spin;

   ilo_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SIDE)
   ) u_prev_row_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (s1_spin_ff),
      .rd_en   (req_xfer),
      .rd_addr (col_ff),
      .rd_data (prev_row_spin)
   );

   ilo_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SIDE)
   ) u_first_row_ram (
      .clock   (clock),
      .wr_en   (s1_fire && s1_first_row_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_spin_ff),
      .rd_en   (req_xfer),
      .rd_addr (col_ff),
      .rd_data (first_row_spin)
   );

   // ------------------------------------------------------------------
   // Bond terms and accumulators
   // ------------------------------------------------------------------
   // -s*x is -1 for aligned spins and +1 for opposed spins
   function automatic logic signed [ilo_pkg::BOND_DELTA_W-1:0] bond_term(
      input logic en,
      input logic a,
      input logic b
   );
      logic signed [ilo_pkg::BOND_DELTA_W-1:0] t;
      if (!en) begin
         t = '0;
      end else if (a == b) begin
         t = -ilo_pkg::BOND_DELTA_W'(1);
      end else begin
         t = ilo_pkg::BOND_DELTA_W'(1);
      end
      return t;
   endfunction

   logic                                    left_spin_ff;
   logic                                    row_first_ff;
   logic signed [ilo_pkg::MAG_SUM_W-1:0]    spin_acc_ff;
   logic signed [ilo_pkg::ENERGY_W-1:0]     energy_acc_ff;
   logic signed [ilo_pkg::BOND_DELTA_W-1:0] bond_delta;
   logic signed [ilo_pkg::MAG_SUM_W-1:0]    spin_acc_in;
   logic signed [ilo_pkg::ENERGY_W-1:0]     energy_acc_in;
   logic                                    snapshot_end;

   assign bond_delta = bond_term(!s1_first_row_ff, s1_spin_ff, prev_row_spin)
                     + bond_term(s1_last_row_ff,   s1_spin_ff, first_row_spin)
                     + bond_term(!s1_first_col_ff, s1_spin_ff, left_spin_ff)
                     + bond_term(s1_last_col_ff,   s1_spin_ff, row_first_ff);

   assign spin_acc_in   = s1_spin_ff ? spin_acc_ff + ilo_pkg::MAG_SUM_W'(1)
                                     : spin_acc_ff - ilo_pkg::MAG_SUM_W'(1);
   assign energy_acc_in = energy_acc_ff + ilo_pkg::ENERGY_W'(bond_delta);
   assign snapshot_end  = s1_last_row_ff && s1_last_col_ff;

   assign s1_emit = snapshot_end && (s1_tidx_ff == (target_ff & IDX_MASK));
   assign s1_fire = s1_valid_ff && (!s1_emit || !rsp_port.valid || rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         left_spin_ff  <= 1'b0;
         row_first_ff  <= 1'b0;
         spin_acc_ff   <= '0;
         energy_acc_ff <= '0;
      end else if (s1_fire) begin
         left_spin_ff <= s1_spin_ff;
         if (s1_first_col_ff) begin
            row_first_ff <= s1_spin_ff;
         end
         // sums start over after a snapshot's last spin
         spin_acc_ff   <= snapshot_end ? '0 : spin_acc_in;
         energy_acc_ff <= snapshot_end ? '0 : energy_acc_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic                                  rsp_valid_ff;
   logic signed [ilo_pkg::MAG_SUM_W-1:0]  rsp_sum_ff;
   logic        [ilo_pkg::MAG_ABS_W-1:0]  rsp_abs_ff;
   logic signed [ilo_pkg::ENERGY_W-1:0]   rsp_energy_ff;
   logic        [TEMP_INDEX_BITS-1:0]     rsp_tidx_ff;
   logic                                  rsp_load;

   assign rsp_load = s1_fire && s1_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sum_ff    <= spin_acc_in;
         rsp_abs_ff    <= ilo_pkg::MAG_ABS_W'(spin_acc_in[ilo_pkg::MAG_SUM_W-1] ?
                                              -spin_acc_in : spin_acc_in);
         rsp_energy_ff <= energy_acc_in;
         rsp_tidx_ff   <= s1_tidx_ff;
      end
   end

   assign rsp_port.valid             = rsp_valid_ff;
   assign rsp_port.magnetization_sum = rsp_sum_ff;
   assign rsp_port.magnetization_abs = rsp_abs_ff;
   assign rsp_port.total_energy      = rsp_energy_ff;
   assign rsp_port.result_temp_index = rsp_tidx_ff;

endmodule
